FILE: src/wcf_pkg.sv
// ----------------------------------------------------------------------------
// wcf_pkg
// Shared types and constants of the window convolution filter: field widths,
// register indexes, default sizes and the tag that travels with each window.
// ----------------------------------------------------------------------------
package wcf_pkg;

  // default sizes, handed to the top level parameters
  localparam int DEF_KSIZE      = 3;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // field and register widths
  localparam int PIX_W         = 8;
  localparam int COEF_W        = 12;
  localparam int COEF_ROW_W    = 60;
  localparam int NUM_COEF_ROWS = 5;
  localparam int DIM_W         = 11;
  localparam int COORD_W       = 10;
  localparam int CFG_IDX_W     = 3;

  // arithmetic: unsigned pixel times signed q4.8 coefficient
  localparam int PROD_W = 20;
  localparam int FRAC_W = 8;

  // window queue between front and back
  localparam int QDEPTH = 4;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // reset value of the frame size registers
  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A  = 3'd0,
    REG_COEF_B  = 3'd1,
    REG_COEF_C  = 3'd2,
    REG_COEF_D  = 3'd3,
    REG_COEF_E  = 3'd4,
    REG_FRAME_W = 3'd5,
    REG_FRAME_H = 3'd6
  } wcf_reg_t;

  // position and end-of-frame flag of one window
  typedef struct packed {
    logic [COORD_W-1:0] center_col;
    logic [COORD_W-1:0] center_row;
    logic               last;
  } wcf_tag_t;

endpackage

FILE: src/window_convolution_filter_top.sv
// An accepted pixel is held in the second front stage, its window is queued,
// then passes the product, row sum, total and output registers. Border pixels
// give no result. Throughput: one pixel per clock while the queue has room,
// set by the line store RAM, read and written once per pixel. Results drain
// at one per clock unless the output stalls. Reset clears position, window,
// queue, pipeline and registers, not the line store, which needs no clearing.
// ----------------------------------------------------------------------------
// window_convolution_filter_top
// 2-D kernel filter over 8-bit grayscale pixels in raster order with a
// configurable signed q4.8 kernel and frame size.
// ----------------------------------------------------------------------------
module window_convolution_filter_top #(
  parameter int KSIZE      = wcf_pkg::DEF_KSIZE,
  parameter int MAX_WIDTH  = wcf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = wcf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [wcf_pkg::PIX_W-1:0]       in_pixel_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [wcf_pkg::PIX_W-1:0]       out_pixel_out,
  output logic [wcf_pkg::COORD_W-1:0]     out_center_col,
  output logic [wcf_pkg::COORD_W-1:0]     out_center_row,
  output logic                            out_frame_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wcf_pkg::COEF_ROW_W-1:0]  cfg_data
);

  localparam int DW    = wcf_pkg::DIM_W;
  localparam int WW    = $clog2(MAX_WIDTH) + 1;
  localparam int HW    = $clog2(MAX_HEIGHT) + 1;
  localparam int EWW   = (WW > DW) ? WW : DW;
  localparam int EHW   = (HW > DW) ? HW : DW;
  localparam int CFW   = wcf_pkg::COEF_W;
  localparam int QW    = KSIZE * KSIZE * wcf_pkg::PIX_W + $bits(wcf_pkg::wcf_tag_t);

  logic [wcf_pkg::COEF_ROW_W-1:0] coef_r [wcf_pkg::NUM_COEF_ROWS];
  logic [DW-1:0]                  frame_w_r, frame_h_r;
  logic [WW-1:0]                  eff_width;
  logic [HW-1:0]                  eff_height;
  logic [KSIZE*KSIZE*CFW-1:0]     coefs;

  logic                           q_push, q_pop, q_not_empty;
  logic [QW-1:0]                  q_push_data, q_pop_data;
  logic [wcf_pkg::QCNT_W-1:0]     q_count;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wcf_pkg::NUM_COEF_ROWS; i++) begin
        coef_r[i] <= '0;
      end
      frame_w_r <= wcf_pkg::DIM_RESET;
      frame_h_r <= wcf_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wcf_pkg::REG_COEF_A:  coef_r[0] <= cfg_data;
        wcf_pkg::REG_COEF_B:  coef_r[1] <= cfg_data;
        wcf_pkg::REG_COEF_C:  coef_r[2] <= cfg_data;
        wcf_pkg::REG_COEF_D:  coef_r[3] <= cfg_data;
        wcf_pkg::REG_COEF_E:  coef_r[4] <= cfg_data;
        wcf_pkg::REG_FRAME_W: frame_w_r <= cfg_data[DW-1:0];
        wcf_pkg::REG_FRAME_H: frame_h_r <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  // frame size in use: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (frame_w_r == '0) begin
      eff_width = WW'(1);
    end else if (EWW'(frame_w_r) > EWW'(MAX_WIDTH)) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(frame_w_r);
    end
    if (frame_h_r == '0) begin
      eff_height = HW'(1);
    end else if (EHW'(frame_h_r) > EHW'(MAX_HEIGHT)) begin
      eff_height = HW'(MAX_HEIGHT);
    end else begin
      eff_height = HW'(frame_h_r);
    end
  end

  // kernel taps in window order
  always_comb begin
    for (int r = 0; r < KSIZE; r++) begin
      for (int c = 0; c < KSIZE; c++) begin
        coefs[(r*KSIZE+c)*CFW +: CFW] = coef_r[r][c*CFW +: CFW];
      end
    end
  end

  // front: position, line store, window
  wcf_front #(
    .KSIZE      (KSIZE),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_pixel_in (in_pixel_in),
    .eff_width   (eff_width),
    .eff_height  (eff_height),
    .q_count     (q_count),
    .q_push      (q_push),
    .q_data      (q_push_data)
  );

  // window queue
  wcf_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_pop_data),
    .count     (q_count)
  );

  // back: multiply, sum, clamp, output register
  wcf_back #(
    .KSIZE (KSIZE)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_data         (q_pop_data),
    .q_pop          (q_pop),
    .coefs          (coefs),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_out  (out_pixel_out),
    .out_center_col (out_center_col),
    .out_center_row (out_center_row),
    .out_frame_last (out_frame_last)
  );

endmodule

FILE: src/wcf_ram.sv
// ----------------------------------------------------------------------------
// wcf_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data. Read during write at the same address gives old data.
// ----------------------------------------------------------------------------
module wcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: src/wcf_front.sv
// ----------------------------------------------------------------------------
// wcf_front
// Front part: accepts pixels, tracks the raster position, keeps the line
// store and the window, and queues every window that lies inside the frame.
// ----------------------------------------------------------------------------
module wcf_front #(
  parameter int KSIZE      = wcf_pkg::DEF_KSIZE,
  parameter int MAX_WIDTH  = wcf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = wcf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [wcf_pkg::PIX_W-1:0]                in_pixel_in,
  input  logic [$clog2(MAX_WIDTH):0]               eff_width,
  input  logic [$clog2(MAX_HEIGHT):0]              eff_height,
  input  logic [wcf_pkg::QCNT_W-1:0]               q_count,
  output logic                                     q_push,
  output logic [KSIZE*KSIZE*wcf_pkg::PIX_W+$bits(wcf_pkg::wcf_tag_t)-1:0] q_data
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int PW     = wcf_pkg::PIX_W;
  localparam int LINE_W = (KSIZE - 1) * PW;
  localparam int COL_W  = KSIZE * PW;
  localparam int WIN_W  = KSIZE * KSIZE * PW;
  localparam int HALF   = KSIZE / 2;
  localparam int CoordW = wcf_pkg::COORD_W;

  logic                 accept;
  logic [CW-1:0]        col_r, col_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [CW:0]          col_inc;
  logic [RW:0]          row_inc;
  logic                 is_inner;
  logic                 is_last;

  logic                 s1_valid_r;
  logic [PW-1:0]        s1_pix_r;
  logic [CW-1:0]        s1_col_r;
  logic                 s1_inner_r;
  wcf_pkg::wcf_tag_t    s1_tag_r;
  logic                 s1_byp_r;
  logic [LINE_W-1:0]    s1_bypd_r;

  logic [LINE_W-1:0]    ram_rdata;
  logic [LINE_W-1:0]    line;
  logic [COL_W-1:0]     column;
  logic [LINE_W-1:0]    line_wdata;
  logic [WIN_W-1:0]     win_r, win_nxt;
  logic [wcf_pkg::QCNT_W:0] pending;

  // hold off while the queue could not take every window in flight
  assign pending  = {1'b0, q_count} + {{wcf_pkg::QCNT_W{1'b0}}, s1_valid_r};
  assign in_stall = (pending >= (wcf_pkg::QCNT_W + 1)'(wcf_pkg::QDEPTH));
  assign accept   = in_valid && !in_stall;

  // raster position of the next pixel
  always_comb begin
    col_inc  = {1'b0, col_r} + (CW + 1)'(1);
    row_inc  = {1'b0, row_r};
    col_nxt  = col_inc[CW-1:0];
    if (col_inc >= eff_width) begin
      col_nxt = '0;
      row_inc = {1'b0, row_r} + (RW + 1)'(1);
    end
    row_nxt = (row_inc >= eff_height) ? '0 : row_inc[RW-1:0];
  end

  // classification of the window completed by this pixel
  assign is_inner = (col_r >= CW'(KSIZE - 1)) && (row_r >= RW'(KSIZE - 1));
  assign is_last  = ({1'b0, col_r} == eff_width - (CW + 1)'(1)) &&
                    ({1'b0, row_r} == eff_height - (RW + 1)'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_byp_r   <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s1_byp_r   <= accept && s1_valid_r && (col_r == s1_col_r);
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // payload of the second front stage
  always_ff @(posedge clk) begin
    s1_bypd_r <= line_wdata;
    if (accept) begin
      s1_pix_r            <= in_pixel_in;
      s1_col_r            <= col_r;
      s1_inner_r          <= is_inner;
      s1_tag_r.center_col <= CoordW'(col_r - CW'(HALF));
      s1_tag_r.center_row <= CoordW'(row_r - RW'(HALF));
      s1_tag_r.last       <= is_last;
    end
  end

  // line store: read at acceptance, shifted column written back in the cycle after
  wcf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (line_wdata),
    .re    (accept),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // forward the column just written when the same address is read back
  assign line       = s1_byp_r ? s1_bypd_r : ram_rdata;
  assign column     = {s1_pix_r, line};
  assign line_wdata = column[COL_W-1:PW];

  // window shifts left, new column enters on the right
  always_comb begin
    for (int r = 0; r < KSIZE; r++) begin
      for (int c = 0; c < KSIZE - 1; c++) begin
        win_nxt[(r*KSIZE+c)*PW +: PW] = win_r[(r*KSIZE+c+1)*PW +: PW];
      end
      win_nxt[(r*KSIZE+KSIZE-1)*PW +: PW] = column[r*PW +: PW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  // inner windows go to the queue
  assign q_push = s1_valid_r && s1_inner_r;
  assign q_data = {win_nxt, s1_tag_r};

endmodule

FILE: src/wcf_queue.sv
// ----------------------------------------------------------------------------
// wcf_queue
// Short first-in first-out queue of windows between the front and back parts.
// ----------------------------------------------------------------------------
module wcf_queue #(
  parameter int WIDTH = 93
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic                       not_empty,
  output logic [WIDTH-1:0]           pop_data,
  output logic [wcf_pkg::QCNT_W-1:0] count
);

  localparam int DEPTH = wcf_pkg::QDEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0]           mem_r [DEPTH];
  logic [PTR_W-1:0]           wr_ptr_r, rd_ptr_r;
  logic [wcf_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign count     = count_r;

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + wcf_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - wcf_pkg::QCNT_W'(1);
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/wcf_back.sv
// ----------------------------------------------------------------------------
// wcf_back
// Back part: multiplies a window by the kernel, sums in a registered tree,
// clamps to a pixel and holds the result in the output register.
// ----------------------------------------------------------------------------
module wcf_back #(
  parameter int KSIZE = wcf_pkg::DEF_KSIZE
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             q_not_empty,
  input  logic [KSIZE*KSIZE*wcf_pkg::PIX_W+$bits(wcf_pkg::wcf_tag_t)-1:0] q_data,
  output logic                                             q_pop,
  input  logic [KSIZE*KSIZE*wcf_pkg::COEF_W-1:0]           coefs,
  output logic                                             out_valid,
  input  logic                                             out_stall,
  output logic [wcf_pkg::PIX_W-1:0]                        out_pixel_out,
  output logic [wcf_pkg::COORD_W-1:0]                      out_center_col,
  output logic [wcf_pkg::COORD_W-1:0]                      out_center_row,
  output logic                                             out_frame_last
);

  localparam int PW     = wcf_pkg::PIX_W;
  localparam int CFW    = wcf_pkg::COEF_W;
  localparam int NTAP   = KSIZE * KSIZE;
  localparam int TAG_W  = $bits(wcf_pkg::wcf_tag_t);
  localparam int PROD_W = wcf_pkg::PROD_W;
  localparam int ACC_W  = PROD_W + $clog2(NTAP);
  localparam int FRAC_W = wcf_pkg::FRAC_W;

  logic                     p_en, r_en, t_en, o_en;
  logic                     p_valid_r, r_valid_r, t_valid_r, out_valid_r;
  wcf_pkg::wcf_tag_t        q_tag, p_tag_r, r_tag_r, t_tag_r;
  logic signed [PROD_W-1:0] prod_nxt [NTAP];
  logic signed [PROD_W-1:0] prod_r   [NTAP];
  logic signed [ACC_W-1:0]  rsum_nxt [KSIZE];
  logic signed [ACC_W-1:0]  rsum_r   [KSIZE];
  logic signed [ACC_W-1:0]  tot_nxt, tot_r;
  logic [PW-1:0]            pix_nxt;

  // stage enables, each stage moves when the one after it has room
  assign o_en  = !out_valid_r || !out_stall;
  assign t_en  = !t_valid_r || o_en;
  assign r_en  = !r_valid_r || t_en;
  assign p_en  = !p_valid_r || r_en;
  assign q_pop = q_not_empty && p_en;
  assign q_tag = q_data[TAG_W-1:0];

  // tap products
  always_comb begin
    logic signed [PW:0]    px;
    logic signed [CFW-1:0] cf;
    for (int i = 0; i < NTAP; i++) begin
      px          = $signed({1'b0, q_data[TAG_W + i*PW +: PW]});
      cf          = $signed(coefs[i*CFW +: CFW]);
      prod_nxt[i] = PROD_W'(px * cf);
    end
  end

  // row sums
  always_comb begin
    for (int r = 0; r < KSIZE; r++) begin
      rsum_nxt[r] = '0;
      for (int c = 0; c < KSIZE; c++) begin
        rsum_nxt[r] = rsum_nxt[r] + ACC_W'(prod_r[r*KSIZE+c]);
      end
    end
  end

  // window total
  always_comb begin
    tot_nxt = '0;
    for (int r = 0; r < KSIZE; r++) begin
      tot_nxt = tot_nxt + rsum_r[r];
    end
  end

  // truncate toward zero and clamp to a pixel
  always_comb begin
    if (tot_r[ACC_W-1] || (tot_r == '0)) begin
      pix_nxt = '0;
    end else if (|tot_r[ACC_W-1:FRAC_W+PW]) begin
      pix_nxt = '1;
    end else begin
      pix_nxt = tot_r[FRAC_W +: PW];
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      r_valid_r   <= 1'b0;
      t_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (p_en) p_valid_r <= q_not_empty;
      if (r_en) r_valid_r <= p_valid_r;
      if (t_en) t_valid_r <= r_valid_r;
      if (o_en) out_valid_r <= t_valid_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod_r  <= prod_nxt;
      p_tag_r <= q_tag;
    end
    if (r_en && p_valid_r) begin
      rsum_r  <= rsum_nxt;
      r_tag_r <= p_tag_r;
    end
    if (t_en && r_valid_r) begin
      tot_r   <= tot_nxt;
      t_tag_r <= r_tag_r;
    end
    if (o_en && t_valid_r) begin
      out_pixel_out  <= pix_nxt;
      out_center_col <= t_tag_r.center_col;
      out_center_row <= t_tag_r.center_row;
      out_frame_last <= t_tag_r.last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: src/wcf_checker.sv
// ----------------------------------------------------------------------------
// wcf_checker
// Port level checks of the window convolution filter, bound to the top level.
// ----------------------------------------------------------------------------
module wcf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [wcf_pkg::PIX_W-1:0]   out_pixel_out,
  input logic [wcf_pkg::COORD_W-1:0] out_center_col,
  input logic [wcf_pkg::COORD_W-1:0] out_center_row,
  input logic                        out_frame_last
);

  // reset empties the result side
  a_reset_no_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

  // input side is ready right after reset
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // a free-running output drains the queue fast enough to keep taking pixels
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |=> !in_stall)
    else $error("input stalled although the output was not stalled");

  // a stalled result holds until its transfer
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out) &&
      $stable(out_center_col) && $stable(out_center_row) && $stable(out_frame_last))
    else $error("stalled result changed");

endmodule

bind window_convolution_filter_top wcf_checker u_wcf_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the window convolution filter. A scoreboard keeps
// its own line stores, window and counters, works out each filtered pixel as
// input transfers are accepted, and compares every output transfer with the
// oldest expected one. Short directed frames cover clamping, tiny and zero
// frame sizes, the spare register index and one long output hold-off.
// Random phases then vary kernel and frame size, with random gaps and
// output stalls.
// ----------------------------------------------------------------------------
module tb;
  import wcf_pkg::*;

  localparam int KS   = DEF_KSIZE;
  localparam int HALF = KS / 2;
  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int MAX_H = DEF_MAX_HEIGHT;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_PIXELS = 880;
  localparam int LIMIT_CYCLES  = 2_000_000;
  localparam int MAX_PRINTS    = 50;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } conv_result_t;

  // scoreboard: own copy of the filter state and the queue of awaited outputs
  class filter_scoreboard;
    logic [COEF_ROW_W-1:0] coef_rows [NUM_COEF_ROWS];
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic [PIX_W-1:0]      lines [KS-1][MAX_W];
    logic [PIX_W-1:0]      win [KS][KS];
    int unsigned           col_pos;
    int unsigned           row_pos;
    conv_result_t          awaited_outputs [$];
    int                    mismatches;

    function new();
      foreach (coef_rows[i]) coef_rows[i] = '0;
      foreach (lines[i, j]) lines[i][j] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      col_pos    = 0;
      row_pos    = 0;
      mismatches = 0;
    endfunction

    function int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function int unsigned frame_pixels();
      return eff_dim(width_reg, MAX_W) * eff_dim(height_reg, MAX_H);
    endfunction

    function int outstanding();
      return awaited_outputs.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_ROW_W-1:0] data);
      case (idx)
        REG_COEF_A, REG_COEF_B, REG_COEF_C, REG_COEF_D, REG_COEF_E: begin
          coef_rows[idx] = data;
        end
        REG_FRAME_W: begin
          width_reg = data[DIM_W-1:0];
        end
        REG_FRAME_H: begin
          height_reg = data[DIM_W-1:0];
        end
        default: begin
          // spare index, write has no effect
        end
      endcase
    endfunction

    // one accepted pixel: shift line stores and window, filter if inside
    function void note_pixel(logic [PIX_W-1:0] p);
      int unsigned  w, h, col, row;
      logic [PIX_W-1:0] column [KS];
      int           sum, k, px;
      conv_result_t res;
      w   = eff_dim(width_reg, MAX_W);
      h   = eff_dim(height_reg, MAX_H);
      col = col_pos;
      row = row_pos;
      if (col >= MAX_W) col = MAX_W - 1;
      for (int r = 0; r < KS - 1; r++) column[r] = lines[r][col];
      column[KS-1] = p;
      for (int r = 0; r < KS - 2; r++) lines[r][col] = lines[r+1][col];
      lines[KS-2][col] = p;
      for (int r = 0; r < KS; r++) begin
        for (int c = 0; c < KS - 1; c++) win[r][c] = win[r][c+1];
        win[r][KS-1] = column[r];
      end
      if (col >= KS - 1 && row >= KS - 1) begin
        sum = 0;
        for (int r = 0; r < KS; r++) begin
          for (int c = 0; c < KS; c++) begin
            px  = int'(win[r][c]);
            k   = int'($signed(coef_rows[r][COEF_W*c +: COEF_W]));
            sum = sum + px * k;
          end
        end
        if (sum <= 0) res.pixel = '0;
        else if ((sum >>> FRAC_W) > 255) res.pixel = '1;
        else res.pixel = PIX_W'(sum >>> FRAC_W);
        res.col  = COORD_W'(col - HALF);
        res.row  = COORD_W'(row - HALF);
        res.last = (col == w - 1) && (row == h - 1);
        awaited_outputs.insert(awaited_outputs.size(), res);
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= h) row = 0;
      col_pos = col;
      row_pos = row;
    endfunction

    task report(string msg);
      if (mismatches < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(conv_result_t got);
      conv_result_t exp;
      if (awaited_outputs.size() == 0) begin
        report($sformatf("unexpected output pixel %0d at col %0d row %0d",
                         got.pixel, got.col, got.row));
        return;
      end
      exp = awaited_outputs.pop_front();
      if (got.pixel !== exp.pixel)
        report($sformatf("pixel_out %0d, expected %0d (col %0d row %0d)",
                         got.pixel, exp.pixel, exp.col, exp.row));
      if (got.col !== exp.col)
        report($sformatf("center_col %0d, expected %0d", got.col, exp.col));
      if (got.row !== exp.row)
        report($sformatf("center_row %0d, expected %0d", got.row, exp.row));
      if (got.last !== exp.last)
        report($sformatf("frame_last %0b, expected %0b (col %0d row %0d)",
                         got.last, exp.last, exp.col, exp.row));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_pixel_in = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIX_W-1:0]      out_pixel_out;
  logic [COORD_W-1:0]    out_center_col;
  logic [COORD_W-1:0]    out_center_row;
  logic                  out_frame_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [COEF_ROW_W-1:0] cfg_data = '0;

  filter_scoreboard      sb = new();
  logic [COEF_ROW_W-1:0] kernel_rows [NUM_COEF_ROWS];
  bit                    in_burst = 1'b0;
  bit                    stall_quiet = 1'b0;
  bit                    hold_off_req = 1'b0;
  int                    pixels_sent = 0;
  int                    cycle_count = 0;

  window_convolution_filter_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_out  (out_pixel_out),
    .out_center_col (out_center_col),
    .out_center_row (out_center_row),
    .out_frame_last (out_frame_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // output side stalls, with one long hold-off on request
  initial begin : result_stall
    int span;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (stall_quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        span = 1 + idle_len();
        repeat (span) @(posedge clk);
      end
    end
  end

  // every output transfer goes to the scoreboard
  always @(posedge clk) begin : result_monitor
    conv_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.pixel = out_pixel_out;
      got.col   = out_center_col;
      got.row   = out_center_row;
      got.last  = out_frame_last;
      sb.check_result(got);
    end
  end

  // one register write; valid stays high for a following write
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_ROW_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // writes kernel_rows and the frame size; either all registers or a random subset
  task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input bit every);
    logic [COEF_ROW_W-1:0] junk;
    int i;
    for (i = 0; i < NUM_COEF_ROWS; i++)
      if (every || $urandom_range(0, 3) != 0)
        put_reg(wcf_reg_t'(REG_COEF_A + i), kernel_rows[i]);
    // junk in the upper bits must be ignored by the size registers
    junk = {28'($urandom()), 32'($urandom())};
    junk[DIM_W-1:0] = w;
    if (every || $urandom_range(0, 3) != 0) put_reg(REG_FRAME_W, junk);
    junk = {28'($urandom()), 32'($urandom())};
    junk[DIM_W-1:0] = h;
    if (every || $urandom_range(0, 3) != 0) put_reg(REG_FRAME_H, junk);
    if (every || $urandom_range(0, 3) == 0)
      put_reg(REG_SPARE, {28'($urandom()), 32'($urandom())});
    cfg_valid <= 1'b0;
  endtask

  // one pixel transfer, then an optional gap
  task automatic send_pixel(input logic [PIX_W-1:0] p);
    int gap;
    in_valid    <= 1'b1;
    in_pixel_in <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(p);
    pixels_sent++;
    gap = in_burst ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frames(input int frames);
    repeat (frames * sb.frame_pixels()) send_pixel(pick_pixel());
  endtask

  // wait until every awaited output has come and border pixels have drained
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [COEF_W-1:0]  k;
    logic [DIM_W-1:0]   w, h;
    int                 style, start_count, i;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // largest positive kernel on bright pixels: sum clamps to 255
    foreach (kernel_rows[r]) kernel_rows[r] = {5{12'h7FF}};
    configure(11'd3, 11'd3, 1'b1);
    for (i = 0; i < 9; i++) send_pixel((i == 4) ? 8'h00 : 8'hFF);
    settle();

    // most negative kernel: negative sums give 0
    foreach (kernel_rows[r]) kernel_rows[r] = {5{12'h800}};
    configure(11'd4, 11'd3, 1'b1);
    for (i = 0; i < 12; i++) send_pixel(i[0] ? 8'hFF : 8'h00);
    settle();

    // zero size acts as one pixel: frames smaller than the kernel never filter
    foreach (kernel_rows[r]) kernel_rows[r] = {5{12'h100}};
    configure(11'd0, 11'd0, 1'b1);
    repeat (3) send_pixel(8'h55);
    settle();
    configure(11'd2, 11'd2, 1'b1);
    send_frames(1);
    settle();

    // long output hold-off while the sender keeps offering pixels
    foreach (kernel_rows[r]) kernel_rows[r] = {28'($urandom()), 32'($urandom())};
    configure(11'd16, 11'd12, 1'b1);
    in_burst     = 1'b1;
    hold_off_req = 1'b1;
    send_frames(1);
    settle();

    // random kernels and small frames
    start_count = pixels_sent;
    while (pixels_sent - start_count < RANDOM_PIXELS) begin
      style = $urandom_range(0, 3);
      for (int r = 0; r < NUM_COEF_ROWS; r++) begin
        for (int c = 0; c < 5; c++) begin
          case (style)
            0: k = COEF_W'($urandom_range(0, 4095));
            1: k = COEF_W'($urandom_range(0, 40));
            2: k = COEF_W'($urandom_range(0, 256)) - 12'd128;
            default: begin
              case ($urandom_range(0, 3))
                0: k = 12'h7FF;
                1: k = 12'h800;
                2: k = 12'hFFF;
                default: k = 12'h000;
              endcase
            end
          endcase
          kernel_rows[r][COEF_W*c +: COEF_W] = k;
        end
      end
      w = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(0, 2))
                                      : DIM_W'($urandom_range(3, 14));
      h = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(0, 2))
                                      : DIM_W'($urandom_range(3, 8));
      in_burst    = ($urandom_range(0, 3) == 0);
      stall_quiet = ($urandom_range(0, 3) == 0);
      configure(w, h, 1'b0);
      send_frames($urandom_range(1, 3));
      settle();
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
